// ----- hdl/crp_pkg.sv -----
// ----------------------------------------------------------------------------
// crp_pkg: shared constants and character classes
// Character codes and small decoders used by the range reference parser.
// ----------------------------------------------------------------------------
`default_nettype none

package crp_pkg;

    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_FOLD    = 8'hDF;

    localparam int COL_RADIX = 26;
    localparam int ROW_RADIX = 10;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
               ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // A/a = 1 .. Z/z = 26
    function automatic logic [4:0] letter_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] u;
        u = (c & CASE_FOLD) - CHAR_UPPER_A + 8'd1;
        return u[4:0];
    endfunction

    function automatic logic [3:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = c - CHAR_ZERO;
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cell_range_reference_parser_top.sv -----
// ----------------------------------------------------------------------------
// cell_range_reference_parser_top: spreadsheet range reference parser
// Parses text such as "B3..AA17" one character per beat into zero-based
// start and end rows and columns, with a failure flag.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one ASCII character per beat in s_tdata; s_tlast
//   marks the final character of a range text. Only that final beat yields a
//   result: one beat on the master channel with both cells in m_tdata and
//   the failure flag in m_tuser. On failure all four fields read zero.
//   The first ".." splits the cells; letters give a base-26 column, the rest
//   is read as a signed integer row (leading whitespace, optional sign).
// Path: a final character is held in the input register, and the state
//   update that consumes it loads the result into the output register.
// Throughput: one character per cycle, sustained save for the stall below;
//   the per-character update is a constant multiply-add and a compare on
//   each accumulator.
// Reset: rst_n clears both beat valid flags and all parse state; the next
//   character starts a new range text.
// Stall: while a result beat waits in the output register, characters that
//   are not final keep flowing; a further final character is held in the
//   input register until the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_range_reference_parser_top
#(
    parameter int COL_BITS = 32,
    parameter int ROW_BITS = 32,
    localparam int DATA_W  = 2 * (ROW_BITS + 1) + 2 * COL_BITS,
    localparam int TDATA_W = ((DATA_W + 7) / 8) * 8
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [crp_pkg::CHAR_W-1:0] s_tdata,  // char_code
    input  wire logic                       s_tlast,  // is_last
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // first_row, first_col, final_row, final_col, zero fill
    output logic [TDATA_W-1:0]              m_tdata,
    output logic                            m_tuser   // parse_failed
);
    import crp_pkg::*;

    localparam int RES_W = DATA_W + 1;

    logic              item_valid;
    logic [CHAR_W-1:0] item_char;
    logic              item_last;
    logic              take;
    logic              out_free;

    logic                res_valid;
    logic [ROW_BITS:0]   res_first_row;
    logic [COL_BITS-1:0] res_first_col;
    logic [ROW_BITS:0]   res_final_row;
    logic [COL_BITS-1:0] res_final_col;
    logic                res_failed;
    logic [RES_W-1:0]    out_word;

    // advance a character unless it is final and the result slot is busy
    assign take = item_valid && (!item_last || out_free);

    crp_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item_char  (item_char),
        .item_last  (item_last)
    );

    crp_core
    #(
        .COL_BITS (COL_BITS),
        .ROW_BITS (ROW_BITS)
    )
    u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (take),
        .char_code     (item_char),
        .is_last       (item_last),
        .res_valid     (res_valid),
        .res_first_row (res_first_row),
        .res_first_col (res_first_col),
        .res_final_row (res_final_row),
        .res_final_col (res_final_col),
        .res_failed    (res_failed)
    );

    crp_out_stage
    #(
        .WIDTH (RES_W)
    )
    u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data ({res_failed, res_final_col, res_final_row,
                     res_first_col, res_first_row}),
        .free      (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    // zero fill above the packed fields
    assign m_tdata = TDATA_W'(out_word[DATA_W-1:0]);
    assign m_tuser = out_word[DATA_W];

endmodule

`default_nettype wire

// ----- hdl/crp_in_stage.sv -----
// ----------------------------------------------------------------------------
// crp_in_stage: input beat register
// Captures one character beat and holds it until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_in_stage
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [crp_pkg::CHAR_W-1:0] s_tdata,
    input  wire logic                       s_tlast,
    input  wire logic                       take,
    output logic                            item_valid,
    output logic [crp_pkg::CHAR_W-1:0]      item_char,
    output logic                            item_last
);
    import crp_pkg::*;

    logic              valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_char  = char_reg;
    assign item_last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload holds without reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/crp_core.sv -----
// ----------------------------------------------------------------------------
// crp_core: range parse state and per-character update
// Advances the cell parser by one character and closes cells at the
// separator and at the last character.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_core
#(
    parameter int COL_BITS = 32,
    parameter int ROW_BITS = 32
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [crp_pkg::CHAR_W-1:0] char_code,
    input  wire logic                       is_last,
    output logic                            res_valid,
    output logic [ROW_BITS:0]               res_first_row,
    output logic [COL_BITS-1:0]             res_first_col,
    output logic [ROW_BITS:0]               res_final_row,
    output logic [COL_BITS-1:0]             res_final_col,
    output logic                            res_failed
);
    import crp_pkg::*;

    localparam int CPW = COL_BITS + 5;
    localparam int RPW = ROW_BITS + 4;

    typedef enum logic [2:0] {
        PH_LETTERS,
        PH_SPACE,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE,
        PH_BAD
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                second_reg, second_next;
    logic                prior_dot_reg, prior_dot_next;
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic                neg_reg, neg_next;
    logic [ROW_BITS:0]   saved_row_reg, saved_row_next;
    logic [COL_BITS-1:0] saved_col_reg, saved_col_next;
    logic                err_reg, err_next;

    logic [CPW-1:0]      col_prod;
    logic                col_ovf;
    logic [ROW_BITS-1:0] row_limit;
    logic [RPW-1:0]      row_prod;
    logic                row_ovf;

    function automatic logic [ROW_BITS:0] close_row(input logic [ROW_BITS-1:0] r,
                                                    input logic n);
        logic [ROW_BITS:0] v;
        v = {1'b0, r};
        if (n)
        begin
            v = -v;
        end
        return v - (ROW_BITS+1)'(1);
    endfunction

    // a dot folded back into the start cell only moves the phase
    function automatic phase_t feed_dot(input phase_t p);
        phase_t q;
        unique case (p)
            PH_LETTERS, PH_SPACE, PH_SIGN: q = PH_BAD;
            PH_DIGITS:                     q = PH_DONE;
            PH_DONE:                       q = PH_DONE;
            default:                       q = PH_BAD;
        endcase
        return q;
    endfunction

    assign col_prod  = CPW'(col_reg) * CPW'(COL_RADIX) + CPW'(letter_value(char_code));
    assign col_ovf   = |col_prod[CPW-1:COL_BITS];
    assign row_limit = {1'b1, {(ROW_BITS-1){1'b0}}} - ROW_BITS'(!neg_reg);
    assign row_prod  = RPW'(row_reg) * RPW'(ROW_RADIX) + RPW'(digit_value(char_code));
    assign row_ovf   = row_prod > RPW'(row_limit);

    always_comb
    begin
        phase_t            ph;
        logic              taken;
        logic              end_err;
        logic              fail;
        logic [ROW_BITS:0] end_row;

        phase_next     = phase_reg;
        second_next    = second_reg;
        prior_dot_next = prior_dot_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        neg_next       = neg_reg;
        saved_row_next = saved_row_reg;
        saved_col_next = saved_col_reg;
        err_next       = err_reg;
        ph             = phase_reg;
        taken          = 1'b0;
        end_err        = 1'b0;
        fail           = 1'b0;
        end_row        = '0;
        res_valid      = 1'b0;
        res_first_row  = '0;
        res_first_col  = '0;
        res_final_row  = '0;
        res_final_col  = '0;
        res_failed     = 1'b0;

        if (step)
        begin
            if (!second_reg && !prior_dot_reg && (char_code == CHAR_DOT))
            begin
                prior_dot_next = 1'b1;
            end
            else if (!second_reg && prior_dot_reg && (char_code == CHAR_DOT))
            begin
                // separator: close the start cell, open the end cell
                prior_dot_next = 1'b0;
                saved_row_next = close_row(row_reg, neg_reg);
                saved_col_next = col_reg - COL_BITS'(1);
                if ((col_reg == '0) || !((phase_reg == PH_DIGITS) || (phase_reg == PH_DONE)))
                begin
                    err_next = 1'b1;
                end
                phase_next  = PH_LETTERS;
                col_next    = '0;
                row_next    = '0;
                neg_next    = 1'b0;
                second_next = 1'b1;
            end
            else
            begin
                prior_dot_next = 1'b0;
                if (!second_reg && prior_dot_reg)
                begin
                    ph = feed_dot(phase_reg);
                end
                if (ph == PH_LETTERS)
                begin
                    if (is_letter(char_code))
                    begin
                        taken = 1'b1;
                        if (col_ovf)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            col_next = col_prod[COL_BITS-1:0];
                        end
                    end
                    else
                    begin
                        ph = PH_SPACE;
                    end
                end
                if (!taken && (ph == PH_SPACE))
                begin
                    if (is_space(char_code))
                    begin
                        taken = 1'b1;
                    end
                    else if ((char_code == CHAR_PLUS) || (char_code == CHAR_MINUS))
                    begin
                        neg_next = (char_code == CHAR_MINUS);
                        ph       = PH_SIGN;
                        taken    = 1'b1;
                    end
                    else
                    begin
                        ph = PH_SIGN;
                    end
                end
                if (!taken && (ph == PH_SIGN))
                begin
                    if (!is_digit(char_code))
                    begin
                        ph    = PH_BAD;
                        taken = 1'b1;
                    end
                    else
                    begin
                        ph = PH_DIGITS;
                    end
                end
                if (!taken && (ph == PH_DIGITS))
                begin
                    if (is_digit(char_code))
                    begin
                        if (row_ovf)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            row_next = row_prod[ROW_BITS-1:0];
                        end
                    end
                    else
                    begin
                        ph = PH_DONE;
                    end
                end
                phase_next = ph;
            end

            if (is_last)
            begin
                // close the end cell, emit, then drop all state
                if (second_next && ((col_next == '0) ||
                    !((phase_next == PH_DIGITS) || (phase_next == PH_DONE))))
                begin
                    end_err = 1'b1;
                end
                end_row   = close_row(row_next, neg_next);
                fail      = err_next || end_err || !second_next;
                res_valid = 1'b1;
                res_failed = fail;
                if (!fail)
                begin
                    res_first_row = saved_row_next;
                    res_first_col = saved_col_next;
                    res_final_row = end_row;
                    res_final_col = col_next - COL_BITS'(1);
                end
                phase_next     = PH_LETTERS;
                second_next    = 1'b0;
                prior_dot_next = 1'b0;
                col_next       = '0;
                row_next       = '0;
                neg_next       = 1'b0;
                saved_row_next = '0;
                saved_col_next = '0;
                err_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LETTERS;
            second_reg    <= 1'b0;
            prior_dot_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            neg_reg       <= 1'b0;
            saved_row_reg <= '0;
            saved_col_reg <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            second_reg    <= second_next;
            prior_dot_reg <= prior_dot_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            neg_reg       <= neg_next;
            saved_row_reg <= saved_row_next;
            saved_col_reg <= saved_col_next;
            err_reg       <= err_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/crp_out_stage.sv -----
// ----------------------------------------------------------------------------
// crp_out_stage: result beat register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_out_stage
#(
    parameter int WIDTH = 131
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic [WIDTH-1:0] load_data,
    output logic                  free,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);
    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/crp_checker.sv -----
// ----------------------------------------------------------------------------
// crp_checker: port-level checks for the range reference parser
// Watches the top-level channels and flags illegal behavior over time.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_checker
#(
    parameter int TDATA_W = 136
)
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic               m_tuser
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // a failed result carries zero fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == '0))
        else $error("failed result carries nonzero fields");

    // the input side stalls only behind a blocked result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a blocked result");

endmodule

bind cell_range_reference_parser_top crp_checker
#(
    .TDATA_W (TDATA_W)
)
u_crp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
